### rtl/windowed_timing_statistics_core_macros.svh
// Assertion macros of the windowed timing statistics checker.
`ifndef WINDOWED_TIMING_STATISTICS_CORE_MACROS_SVH
`define WINDOWED_TIMING_STATISTICS_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define WTS_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("windowed timing statistics check failed");

// Consequent must hold in the cycle after the antecedent.
`define WTS_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("windowed timing statistics check failed");

`endif

### rtl/wts_pkg.sv
// Shared constants, types and helpers of the windowed timing statistics core.
package wts_pkg;

  localparam int WINDOW  = 64;
  localparam int METRICS = 4;

  localparam int IN_W   = 32;
  localparam int VAL_W  = 31;
  localparam int UND_W  = 32;
  localparam int RATE_W = 24;

  localparam int ADDR_W = $clog2(WINDOW);
  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam int SUM_W  = VAL_W + ADDR_W;
  localparam int MIDX_W = (METRICS > 1) ? $clog2(METRICS) : 1;
  localparam int EIDX_W = $clog2(METRICS + 1);
  localparam int STEP_W = $clog2(SUM_W + 1);

  // 1000 ms in Q16.8 over a Q21.10 interval
  localparam int RATE_NUM = 1000 * (2 ** 18);

  // Percentile rank ceil(0.95 * n) = floor((n * 95 + 99) / 100)
  localparam int PCT_NUM  = 95;
  localparam int PCT_BIAS = 99;
  localparam int PCT_DEN  = 100;
  localparam int RCP_SH   = 24;
  localparam int RCP_MUL  = (2 ** RCP_SH + PCT_DEN - 1) / PCT_DEN;
  localparam int RANK_W   = $clog2(WINDOW * PCT_NUM + PCT_BIAS + 1);

  localparam logic OP_PUSH    = 1'b0;
  localparam logic OP_SUMMARY = 1'b1;

  typedef logic [VAL_W-1:0] val_t;
  typedef logic [METRICS-1:0][VAL_W-1:0] row_t;
  typedef logic [METRICS-1:0][IN_W-1:0] metric_in_t;

  typedef struct packed {
    logic push;
    logic clr;
    logic sweep_start;
    logic mode_count;
    logic div_go;
    logic rd_j;
    logic cand_cap;
    logic eval;
    logic lat_cap;
    logic emit;
  } wts_cmd_t;

  typedef struct packed {
    logic empty;
    logic sweep_done;
    logic div_done;
    logic div_last;
    logic pct_done;
    logic emit_last;
  } wts_stat_t;

  function automatic logic [CNT_W-1:0] rank_of(input logic [CNT_W-1:0] n);
    logic [RANK_W-1:0]        x;
    logic [RANK_W+RCP_SH-1:0] p;
    x = RANK_W'(n) * RANK_W'(PCT_NUM) + RANK_W'(PCT_BIAS);
    p = (RANK_W + RCP_SH)'(x) * (RANK_W + RCP_SH)'(RCP_MUL);
    return CNT_W'(p >> RCP_SH);
  endfunction

endpackage

### rtl/windowed_timing_statistics_core.sv
// Top level of the windowed timing statistics core: register port, controller, datapath.
//
//  channel  | handshake                          | beat content
//  ---------+------------------------------------+-------------------------------------
//  input    | start & !busy                      | operation, four metrics, audio status
//  result   | out_valid, one cycle, no backpress | statistics of one metric per beat
//  config   | psel & penable & pwrite (pready=1) | interval_metric at word 0
//
// A push is taken in idle; its single result beat follows in the next cycle and busy stays low.
// A summary over n held samples walks the window memory, one row per cycle: a sweep of sums
// and extremes, 5 divisions (four means, then the frame rate), a percentile search (one
// candidate row against all rows per sweep), then 4 result beats.
// The window memory has a single read port, so each sweep reads its rows one at a time.
// rst_n is synchronous; it clears the window count, write slot, audio status and register.
module windowed_timing_statistics_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_operation,
  input  logic signed [wts_pkg::IN_W-1:0] in_metric_0,
  input  logic signed [wts_pkg::IN_W-1:0] in_metric_1,
  input  logic signed [wts_pkg::IN_W-1:0] in_metric_2,
  input  logic signed [wts_pkg::IN_W-1:0] in_metric_3,
  input  logic                          in_audio_present,
  input  logic signed [wts_pkg::IN_W-1:0] in_audio_queue_in,
  input  logic [wts_pkg::UND_W-1:0]     in_audio_underrun_in,
  output logic                          out_valid,
  output logic                          out_accepted,
  output logic [wts_pkg::VAL_W-1:0]     out_latest,
  output logic [wts_pkg::VAL_W-1:0]     out_mean,
  output logic [wts_pkg::VAL_W-1:0]     out_minimum,
  output logic [wts_pkg::VAL_W-1:0]     out_maximum,
  output logic [wts_pkg::VAL_W-1:0]     out_percentile_95,
  output logic [wts_pkg::CNT_W-1:0]     out_sample_count,
  output logic [wts_pkg::RATE_W-1:0]    out_frame_rate,
  output logic                          out_audio_present_out,
  output logic [wts_pkg::VAL_W-1:0]     out_audio_queue_out,
  output logic [wts_pkg::UND_W-1:0]     out_audio_underrun_out,
  output logic                          out_last,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import wts_pkg::*;

  logic [1:0] intv_r;
  logic       cfg_wr;
  metric_in_t metrics;
  wts_cmd_t   cmd;
  wts_stat_t  stat;

  // Word 0 holds the interval metric select; other words are ignored on write.
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == 1'b0);
  assign pready = 1'b1;
  assign prdata = paddr[2] ? '0 : 32'(intv_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      intv_r <= '0;
    end else if (cfg_wr) begin
      intv_r <= pwdata[1:0];
    end
  end

  // Gather the metric ports into one row
  assign metrics[0] = in_metric_0;
  assign metrics[1] = in_metric_1;
  assign metrics[2] = in_metric_2;
  assign metrics[3] = in_metric_3;

  wts_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .op    (in_operation),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  wts_dpath u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .intv             (intv_r),
    .metric_in        (metrics),
    .audio_present    (in_audio_present),
    .audio_queue      (in_audio_queue_in),
    .audio_underrun   (in_audio_underrun_in),
    .res_valid        (out_valid),
    .res_accepted     (out_accepted),
    .res_latest       (out_latest),
    .res_mean         (out_mean),
    .res_minimum      (out_minimum),
    .res_maximum      (out_maximum),
    .res_pct          (out_percentile_95),
    .res_count        (out_sample_count),
    .res_rate         (out_frame_rate),
    .res_aud_flag     (out_audio_present_out),
    .res_aud_queue    (out_audio_queue_out),
    .res_aud_underrun (out_audio_underrun_out),
    .res_last         (out_last)
  );

endmodule

### rtl/wts_div.sv
// Restoring divider, one quotient bit per cycle.
module wts_div (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     go,
  input  logic [wts_pkg::SUM_W-1:0] dividend,
  input  logic [wts_pkg::VAL_W-1:0] divisor,
  output logic                     done,
  output logic [wts_pkg::SUM_W-1:0] quotient
);
  import wts_pkg::*;

  logic              run_r, run_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  logic [VAL_W-1:0]  rem_r;
  logic [VAL_W-1:0]  dvs_r;
  logic [SUM_W-1:0]  quo_r;
  logic [VAL_W:0]    trial;
  logic [VAL_W:0]    diff;
  logic              ge;

  always_comb begin
    trial = {rem_r, quo_r[SUM_W-1]};
    diff  = trial - {1'b0, dvs_r};
    ge    = (trial >= {1'b0, dvs_r});
  end

  always_comb begin
    run_nxt  = run_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (go) begin
      run_nxt = 1'b1;
      cnt_nxt = '0;
    end else if (run_r) begin
      cnt_nxt = cnt_r + STEP_W'(1);
      if (cnt_r == STEP_W'(SUM_W - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      rem_r <= '0;
      dvs_r <= divisor;
      quo_r <= dividend;
    end else if (run_r) begin
      rem_r <= ge ? diff[VAL_W-1:0] : trial[VAL_W-1:0];
      quo_r <= {quo_r[SUM_W-2:0], ge};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

### rtl/wts_dpath.sv
// Datapath: sample memory, window sweeps, statistics, percentile search, results.
module wts_dpath (
  input  logic                       clk,
  input  logic                       rst_n,
  input  wts_pkg::wts_cmd_t          cmd,
  output wts_pkg::wts_stat_t         stat,
  input  logic [1:0]                 intv,
  input  wts_pkg::metric_in_t        metric_in,
  input  logic                       audio_present,
  input  logic [wts_pkg::IN_W-1:0]   audio_queue,
  input  logic [wts_pkg::UND_W-1:0]  audio_underrun,
  output logic                       res_valid,
  output logic                       res_accepted,
  output logic [wts_pkg::VAL_W-1:0]  res_latest,
  output logic [wts_pkg::VAL_W-1:0]  res_mean,
  output logic [wts_pkg::VAL_W-1:0]  res_minimum,
  output logic [wts_pkg::VAL_W-1:0]  res_maximum,
  output logic [wts_pkg::VAL_W-1:0]  res_pct,
  output logic [wts_pkg::CNT_W-1:0]  res_count,
  output logic [wts_pkg::RATE_W-1:0] res_rate,
  output logic                       res_aud_flag,
  output logic [wts_pkg::VAL_W-1:0]  res_aud_queue,
  output logic [wts_pkg::UND_W-1:0]  res_aud_underrun,
  output logic                       res_last
);
  import wts_pkg::*;

  row_t mem [WINDOW];
  row_t rd_data_r;
  row_t wr_row;

  logic [ADDR_W-1:0] wr_slot_r, k_r, j_r, recent, rd_addr;
  logic [CNT_W-1:0]  count_r, rank;
  logic              aud_flag_r;
  val_t              aud_q_r;
  logic [UND_W-1:0]  aud_un_r;
  logic              sweep_on_r, dv_r, dlast_r, skip_r;
  logic [EIDX_W-1:0] e_r;
  logic [MIDX_W-1:0] eidx;
  logic              e_is_rate;

  logic [SUM_W-1:0] sum_r [METRICS];
  val_t             min_r [METRICS];
  val_t             max_r [METRICS];
  val_t             mean_r [METRICS];
  val_t             cand_r [METRICS];
  val_t             pct_r [METRICS];
  val_t             latest_r [METRICS];
  logic [CNT_W-1:0] lt_r [METRICS];
  logic [CNT_W-1:0] le_r [METRICS];
  logic [METRICS-1:0] found_r, hit;
  val_t             intv_mean_r;
  logic [RATE_W-1:0] rate_r;

  logic             push_ok, intv_ok, rate_skip, div_done;
  logic [SUM_W-1:0] div_dividend, div_quo;
  val_t             div_divisor;

  always_comb begin
    push_ok = !(audio_present && audio_queue[IN_W-1]);
    for (int m = 0; m < METRICS; m++) begin
      if (metric_in[m][IN_W-1]) push_ok = 1'b0;
      wr_row[m] = metric_in[m][VAL_W-1:0];
    end
  end

  assign recent  = (wr_slot_r == '0) ? ADDR_W'(WINDOW - 1) : wr_slot_r - ADDR_W'(1);
  assign rd_addr = sweep_on_r ? k_r : (cmd.rd_j ? j_r : recent);
  assign rank    = rank_of(count_r);
  assign eidx    = e_r[MIDX_W-1:0];
  assign e_is_rate = (e_r == EIDX_W'(METRICS));
  assign intv_ok   = (int'(intv) < METRICS);
  assign rate_skip = !intv_ok || (intv_mean_r == '0);

  always_comb begin
    for (int m = 0; m < METRICS; m++)
      hit[m] = (lt_r[m] < rank) && (rank <= le_r[m]);
  end

  // Divider: per-metric mean, then the frame rate
  assign div_dividend = e_is_rate ? SUM_W'(RATE_NUM) : sum_r[eidx];
  assign div_divisor  = e_is_rate ? intv_mean_r : VAL_W'(count_r);

  wts_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (cmd.div_go && !(e_is_rate && rate_skip)),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_comb begin
    stat.empty      = (count_r == '0);
    stat.sweep_done = dlast_r;
    stat.div_done   = div_done || skip_r;
    stat.div_last   = e_is_rate;
    stat.pct_done   = (&(found_r | hit)) || ((CNT_W'(j_r) + CNT_W'(1)) == count_r);
    stat.emit_last  = (e_r == EIDX_W'(METRICS - 1));
  end

  always_ff @(posedge clk) begin
    if (cmd.push && push_ok) mem[wr_slot_r] <= wr_row;
    rd_data_r <= mem[rd_addr];
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_slot_r  <= '0;
      count_r    <= '0;
      aud_flag_r <= 1'b0;
      aud_q_r    <= '0;
      aud_un_r   <= '0;
      sweep_on_r <= 1'b0;
      dv_r       <= 1'b0;
      dlast_r    <= 1'b0;
      skip_r     <= 1'b0;
      e_r        <= '0;
      j_r        <= '0;
      k_r        <= '0;
      res_valid  <= 1'b0;
    end else begin
      dv_r      <= sweep_on_r;
      dlast_r   <= sweep_on_r && ((CNT_W'(k_r) + CNT_W'(1)) == count_r);
      skip_r    <= cmd.div_go && e_is_rate && rate_skip;
      res_valid <= cmd.push || cmd.emit;
      if (cmd.push && push_ok) begin
        wr_slot_r  <= (wr_slot_r == ADDR_W'(WINDOW - 1)) ? '0 : wr_slot_r + ADDR_W'(1);
        if (count_r != CNT_W'(WINDOW)) count_r <= count_r + CNT_W'(1);
        aud_flag_r <= audio_present;
        aud_q_r    <= audio_queue[IN_W-1] ? '0 : audio_queue[VAL_W-1:0];
        aud_un_r   <= audio_underrun;
      end
      if (cmd.sweep_start) begin
        k_r        <= '0;
        sweep_on_r <= 1'b1;
      end else if (sweep_on_r) begin
        k_r <= k_r + ADDR_W'(1);
        if ((CNT_W'(k_r) + CNT_W'(1)) == count_r) sweep_on_r <= 1'b0;
      end
      if (cmd.clr || cmd.lat_cap) e_r <= '0;
      else if (div_done || skip_r || cmd.emit) e_r <= e_r + EIDX_W'(1);
      if (cmd.clr) j_r <= '0;
      else if (cmd.eval) j_r <= j_r + ADDR_W'(1);
    end
  end

  // Statistics and percentile lanes
  always_ff @(posedge clk) begin
    if (cmd.clr) found_r <= '0;
    else if (cmd.eval) found_r <= found_r | hit;
    for (int m = 0; m < METRICS; m++) begin
      if (cmd.clr) begin
        sum_r[m] <= '0;
        min_r[m] <= '1;
        max_r[m] <= '0;
      end else if (dv_r && !cmd.mode_count) begin
        sum_r[m] <= sum_r[m] + SUM_W'(rd_data_r[m]);
        if (rd_data_r[m] < min_r[m]) min_r[m] <= rd_data_r[m];
        if (rd_data_r[m] > max_r[m]) max_r[m] <= rd_data_r[m];
      end
      if (cmd.cand_cap) begin
        cand_r[m] <= rd_data_r[m];
        lt_r[m]   <= '0;
        le_r[m]   <= '0;
      end else if (dv_r && cmd.mode_count) begin
        lt_r[m] <= lt_r[m] + CNT_W'(rd_data_r[m] < cand_r[m]);
        le_r[m] <= le_r[m] + CNT_W'(rd_data_r[m] <= cand_r[m]);
      end
      if (cmd.eval && hit[m] && !found_r[m]) pct_r[m] <= cand_r[m];
      if (cmd.lat_cap) latest_r[m] <= rd_data_r[m];
      if (div_done && !e_is_rate && (eidx == MIDX_W'(m))) mean_r[m] <= div_quo[VAL_W-1:0];
    end
    // Hold the interval metric's mean as the rate divisor
    if (cmd.clr) intv_mean_r <= '0;
    else if (div_done && !e_is_rate && intv_ok && (int'(eidx) == int'(intv)))
      intv_mean_r <= div_quo[VAL_W-1:0];
    if (skip_r) rate_r <= '0;
    else if (div_done && e_is_rate)
      rate_r <= (|div_quo[SUM_W-1:RATE_W]) ? '1 : div_quo[RATE_W-1:0];
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      res_accepted     <= push_ok;
      res_latest       <= '0;
      res_mean         <= '0;
      res_minimum      <= '0;
      res_maximum      <= '0;
      res_pct          <= '0;
      res_count        <= '0;
      res_rate         <= '0;
      res_aud_flag     <= 1'b0;
      res_aud_queue    <= '0;
      res_aud_underrun <= '0;
      res_last         <= 1'b1;
    end else if (cmd.emit) begin
      res_accepted     <= 1'b1;
      res_latest       <= stat.empty ? '0 : latest_r[eidx];
      res_mean         <= stat.empty ? '0 : mean_r[eidx];
      res_minimum      <= stat.empty ? '0 : min_r[eidx];
      res_maximum      <= stat.empty ? '0 : max_r[eidx];
      res_pct          <= stat.empty ? '0 : pct_r[eidx];
      res_count        <= count_r;
      res_rate         <= stat.empty ? '0 : rate_r;
      res_aud_flag     <= stat.empty ? 1'b0 : aud_flag_r;
      res_aud_queue    <= stat.empty ? '0 : aud_q_r;
      res_aud_underrun <= stat.empty ? '0 : aud_un_r;
      res_last         <= stat.emit_last;
    end
  end

endmodule

### rtl/wts_ctrl.sv
// Controller: sequences push, window sweeps, divisions, percentile search and emission.
module wts_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               op,
  input  wts_pkg::wts_stat_t stat,
  output wts_pkg::wts_cmd_t  cmd,
  output logic               busy
);
  import wts_pkg::*;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_SCAN_GO  = 4'd1;
  localparam logic [3:0] S_SCAN     = 4'd2;
  localparam logic [3:0] S_DIV_GO   = 4'd3;
  localparam logic [3:0] S_DIV      = 4'd4;
  localparam logic [3:0] S_PCT_RD   = 4'd5;
  localparam logic [3:0] S_PCT_CAP  = 4'd6;
  localparam logic [3:0] S_PCT      = 4'd7;
  localparam logic [3:0] S_PCT_EVAL = 4'd8;
  localparam logic [3:0] S_LAT_RD   = 4'd9;
  localparam logic [3:0] S_LAT_CAP  = 4'd10;
  localparam logic [3:0] S_EMIT     = 4'd11;

  logic [3:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          if (op == OP_PUSH) begin
            cmd.push = 1'b1;
          end else begin
            cmd.clr   = 1'b1;
            state_nxt = stat.empty ? S_EMIT : S_SCAN_GO;
          end
        end
      end
      S_SCAN_GO: begin
        cmd.sweep_start = 1'b1;
        state_nxt       = S_SCAN;
      end
      S_SCAN: begin
        if (stat.sweep_done) state_nxt = S_DIV_GO;
      end
      S_DIV_GO: begin
        cmd.div_go = 1'b1;
        state_nxt  = S_DIV;
      end
      S_DIV: begin
        if (stat.div_done) state_nxt = stat.div_last ? S_PCT_RD : S_DIV_GO;
      end
      S_PCT_RD: begin
        cmd.rd_j  = 1'b1;
        state_nxt = S_PCT_CAP;
      end
      S_PCT_CAP: begin
        cmd.cand_cap    = 1'b1;
        cmd.sweep_start = 1'b1;
        state_nxt       = S_PCT;
      end
      S_PCT: begin
        cmd.mode_count = 1'b1;
        if (stat.sweep_done) state_nxt = S_PCT_EVAL;
      end
      S_PCT_EVAL: begin
        cmd.eval  = 1'b1;
        state_nxt = stat.pct_done ? S_LAT_RD : S_PCT_RD;
      end
      S_LAT_RD: begin
        state_nxt = S_LAT_CAP;
      end
      S_LAT_CAP: begin
        cmd.lat_cap = 1'b1;
        state_nxt   = S_EMIT;
      end
      S_EMIT: begin
        cmd.emit = 1'b1;
        if (stat.emit_last) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

### rtl/wts_checker.sv
// Port-level checker of the windowed timing statistics core, bound to the top level.
`include "windowed_timing_statistics_core_macros.svh"

module wts_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        start,
  input logic                        busy,
  input logic                        in_operation,
  input logic                        out_valid,
  input logic                        out_accepted,
  input logic                        out_last,
  input logic [wts_pkg::CNT_W-1:0]   out_sample_count,
  input logic [wts_pkg::VAL_W-1:0]   out_mean,
  input logic [wts_pkg::VAL_W-1:0]   out_minimum,
  input logic [wts_pkg::VAL_W-1:0]   out_maximum,
  input logic [wts_pkg::VAL_W-1:0]   out_percentile_95
);
  import wts_pkg::*;

  // A push answers with a single final beat in the next cycle
  `WTS_ASSERT_NEXT(a_push_reply, start && !busy && in_operation == OP_PUSH, out_valid && out_last)
  // A summary holds the core busy
  `WTS_ASSERT_NEXT(a_sum_busy, start && !busy && in_operation == OP_SUMMARY, busy)
  // A refused push carries nothing but the final mark
  `WTS_ASSERT_NOW(a_refused, out_valid && !out_accepted, out_last && out_sample_count == '0 && out_mean == '0)
  // Statistics of a non-empty window stay ordered
  `WTS_ASSERT_NOW(a_order, out_valid && out_accepted && out_sample_count != '0, out_minimum <= out_percentile_95 && out_percentile_95 <= out_maximum && out_minimum <= out_mean && out_mean <= out_maximum)

endmodule

bind windowed_timing_statistics_core wts_checker u_wts_checker (.*);

### tb/tb_windowed_timing_statistics_core.sv
// Testbench of the windowed timing statistics core: table-driven and random stimulus.
module tb_windowed_timing_statistics_core;
  timeunit 1ns;
  timeprecision 1ps;
  import wts_pkg::*;

  // Stall limit in cycles, well above the length of a summary over a full window.
  localparam int STALL_LIMIT  = 20000;
  localparam int RANDOM_ITEMS = 80;
  localparam int CFG_INTERVAL = 0;

  // One input beat, plus an optional typed-in expectation for table rows.
  typedef struct packed {
    logic                         op;
    logic [METRICS-1:0][IN_W-1:0] met;
    logic                         ap;
    logic [IN_W-1:0]              aq;
    logic [UND_W-1:0]             au;
    logic                         typed;
    logic                         exp_acc;
  } stim_t;

  // One result beat, in port order.
  typedef struct packed {
    logic              acc;
    val_t              lat;
    val_t              avg;
    val_t              mn;
    val_t              mx;
    val_t              p95;
    logic [CNT_W-1:0]  cnt;
    logic [RATE_W-1:0] rate;
    logic              ap;
    val_t              aq;
    logic [UND_W-1:0]  au;
    logic              last;
  } stat_t;

  logic clk = 1'b0;
  logic rst_n;
  logic start;
  logic busy;
  logic in_operation;
  logic signed [IN_W-1:0] in_metric_0, in_metric_1, in_metric_2, in_metric_3;
  logic in_audio_present;
  logic signed [IN_W-1:0] in_audio_queue_in;
  logic [UND_W-1:0] in_audio_underrun_in;
  logic out_valid, out_accepted, out_audio_present_out, out_last;
  logic [VAL_W-1:0] out_latest, out_mean, out_minimum, out_maximum, out_percentile_95;
  logic [VAL_W-1:0] out_audio_queue_out;
  logic [CNT_W-1:0] out_sample_count;
  logic [RATE_W-1:0] out_frame_rate;
  logic [UND_W-1:0] out_audio_underrun_out;
  logic psel, penable, pwrite, pready;
  logic [2:0] paddr;
  logic [31:0] pwdata, prdata;

  always #10 clk = ~clk;

  windowed_timing_statistics_core u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_operation(in_operation),
    .in_metric_0(in_metric_0), .in_metric_1(in_metric_1),
    .in_metric_2(in_metric_2), .in_metric_3(in_metric_3),
    .in_audio_present(in_audio_present), .in_audio_queue_in(in_audio_queue_in),
    .in_audio_underrun_in(in_audio_underrun_in),
    .out_valid(out_valid), .out_accepted(out_accepted), .out_latest(out_latest),
    .out_mean(out_mean), .out_minimum(out_minimum), .out_maximum(out_maximum),
    .out_percentile_95(out_percentile_95), .out_sample_count(out_sample_count),
    .out_frame_rate(out_frame_rate), .out_audio_present_out(out_audio_present_out),
    .out_audio_queue_out(out_audio_queue_out),
    .out_audio_underrun_out(out_audio_underrun_out), .out_last(out_last),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Shadow of the block: window contents, ring pointer, fill level, latest audio status.
  val_t              win_store [WINDOW][METRICS];
  int                wr_slot;
  int                fill;
  logic              lat_ap;
  val_t              lat_aq;
  logic [UND_W-1:0]  lat_au;
  logic [1:0]        interval_sel;

  stat_t pending_stats[$];
  int    mismatches;
  int    pushes_stored, pushes_refused, summaries, beats_checked;
  int    burst_left;
  int    idle_cycles;

  // Work out the result beats of one accepted input beat and advance the shadow state.
  task automatic predict_stats(input stim_t s);
    stat_t            r;
    stat_t            beats[$];
    logic             ok;
    longint unsigned  sum;
    longint unsigned  rate;
    logic [31:0]      means [METRICS];
    int               n, rank, recent;
    val_t             col[$];
    if (s.op == OP_PUSH) begin
      ok = 1'b1;
      for (int m = 0; m < METRICS; m++) if (s.met[m][IN_W-1]) ok = 1'b0;
      // the queue depth only matters when audio rides along
      if (s.ap && s.aq[IN_W-1]) ok = 1'b0;
      r = '0;
      r.acc = s.typed ? s.exp_acc : ok;
      r.last = 1'b1;
      beats.push_back(r);
      if (ok) begin
        for (int m = 0; m < METRICS; m++) win_store[wr_slot][m] = s.met[m][VAL_W-1:0];
        lat_ap = s.ap;
        lat_aq = s.aq[IN_W-1] ? '0 : s.aq[VAL_W-1:0];
        lat_au = s.au;
        wr_slot = (wr_slot + 1) % WINDOW;
        if (fill < WINDOW) fill++;
        pushes_stored++;
      end else begin
        pushes_refused++;
      end
    end else begin
      summaries++;
      n = s.typed ? 0 : fill;
      recent = (wr_slot + WINDOW - 1) % WINDOW;
      rate = 0;
      for (int m = 0; m < METRICS; m++) begin
        sum = 0;
        for (int i = 0; i < n; i++) sum += win_store[i][m];
        means[m] = (n > 0) ? 32'(sum / longint'(n)) : '0;
      end
      if (n > 0 && interval_sel < METRICS && means[interval_sel] != 0) begin
        rate = longint'(RATE_NUM) / means[interval_sel];
        if (rate > 64'hFF_FFFF) rate = 64'hFF_FFFF;
      end
      rank = (n * PCT_NUM + PCT_BIAS) / PCT_DEN;
      if (rank < 1) rank = 1;
      if (rank > n) rank = n;
      for (int m = 0; m < METRICS; m++) begin
        r = '0;
        r.acc = 1'b1;
        r.last = (m == METRICS - 1);
        if (n > 0) begin
          col.delete();
          for (int i = 0; i < n; i++) col.push_back(win_store[i][m]);
          col.sort();
          r.lat  = win_store[recent][m];
          r.avg  = means[m][VAL_W-1:0];
          r.mn   = col[0];
          r.mx   = col[n-1];
          r.p95  = col[rank-1];
          r.cnt  = CNT_W'(n);
          r.rate = RATE_W'(rate);
          r.ap   = lat_ap;
          r.aq   = lat_aq;
          r.au   = lat_au;
        end
        beats.push_back(r);
      end
    end
    foreach (beats[i]) pending_stats.push_back(beats[i]);
  endtask

  task automatic report_mismatch(input string field, input longint got, input longint want);
    $display("mismatch at %0t: %s got 0x%0h expected 0x%0h", $realtime, field, got, want);
    mismatches++;
  endtask

  // Result side: every strobed beat must match the oldest expectation.
  always @(posedge clk) begin
    stat_t w;
    if (rst_n && out_valid) begin
      if (pending_stats.size() == 0) begin
        report_mismatch("unexpected beat, accepted", out_accepted, 0);
      end else begin
        w = pending_stats.pop_front();
        beats_checked++;
        if (out_accepted !== w.acc) report_mismatch("accepted", out_accepted, w.acc);
        if (out_latest !== w.lat) report_mismatch("latest", out_latest, w.lat);
        if (out_mean !== w.avg) report_mismatch("mean", out_mean, w.avg);
        if (out_minimum !== w.mn) report_mismatch("minimum", out_minimum, w.mn);
        if (out_maximum !== w.mx) report_mismatch("maximum", out_maximum, w.mx);
        if (out_percentile_95 !== w.p95)
          report_mismatch("percentile_95", out_percentile_95, w.p95);
        if (out_sample_count !== w.cnt)
          report_mismatch("sample_count", out_sample_count, w.cnt);
        if (out_frame_rate !== w.rate) report_mismatch("frame_rate", out_frame_rate, w.rate);
        if (out_audio_present_out !== w.ap)
          report_mismatch("audio_present_out", out_audio_present_out, w.ap);
        if (out_audio_queue_out !== w.aq)
          report_mismatch("audio_queue_out", out_audio_queue_out, w.aq);
        if (out_audio_underrun_out !== w.au)
          report_mismatch("audio_underrun_out", out_audio_underrun_out, w.au);
        if (out_last !== w.last) report_mismatch("last", out_last, w.last);
      end
    end
  end

  // Watchdog: count cycles in which no beat moves on any channel.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || psel) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("stalled for %0d cycles with %0d beats outstanding",
               idle_cycles, pending_stats.size());
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic stim_t row(input logic op, input logic [31:0] m0, input logic [31:0] m1,
                                input logic [31:0] m2, input logic [31:0] m3,
                                input logic ap, input logic [31:0] aq, input logic [31:0] au,
                                input logic typed = 1'b0, input logic exp_acc = 1'b0);
    stim_t s;
    s.op = op;
    s.met = {m3, m2, m1, m0};
    s.ap = ap;
    s.aq = aq;
    s.au = au;
    s.typed = typed;
    s.exp_acc = exp_acc;
    return s;
  endfunction

  // Pick a metric value: mostly frame-like times, sometimes tiny, zero or full range.
  function automatic logic [31:0] pick_metric();
    int k;
    k = $urandom_range(0, 9);
    if (k < 5) return 32'(16 * 1024 + $urandom_range(0, 4096) - 2048);
    if (k < 7) return 32'($urandom_range(0, 3));
    return {1'b0, 31'($urandom)};
  endfunction

  function automatic stim_t pick_stim();
    stim_t s;
    int k;
    s = '0;
    k = $urandom_range(0, 99);
    if (k < 78) begin
      // well-formed push with random content
      s.op = OP_PUSH;
      for (int m = 0; m < METRICS; m++) s.met[m] = pick_metric();
      s.ap = $urandom_range(0, 1);
      s.aq = {1'b0, 31'($urandom)};
      s.au = $urandom;
    end else if (k < 92) begin
      s.op = OP_SUMMARY;
      for (int m = 0; m < METRICS; m++) s.met[m] = $urandom;
      s.ap = $urandom_range(0, 1);
      s.aq = $urandom;
      s.au = $urandom;
    end else begin
      // noise: raw words, usually refused
      s.op = OP_PUSH;
      for (int m = 0; m < METRICS; m++) s.met[m] = $urandom;
      s.ap = $urandom_range(0, 1);
      s.aq = $urandom;
      s.au = $urandom;
    end
    return s;
  endfunction

  // Present one beat, hold it until taken, then maybe open a gap.
  task automatic send_beat(input stim_t s);
    int gap;
    start <= 1'b1;
    in_operation <= s.op;
    in_metric_0 <= s.met[0];
    in_metric_1 <= s.met[1];
    in_metric_2 <= s.met[2];
    in_metric_3 <= s.met[3];
    in_audio_present <= s.ap;
    in_audio_queue_in <= s.aq;
    in_audio_underrun_in <= s.au;
    do @(posedge clk); while (busy);
    predict_stats(s);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 12);
      // a third of the bursts run straight into the next one
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Drain: drop start, wait until every expected beat is in and the core is idle.
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (pending_stats.size() != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_interval(input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 3'(4 * CFG_INTERVAL);
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    interval_sel = value[1:0];
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    stim_t dir_rows[$];
    logic [31:0] phase_cfg [4];
    // drive everything known before the first edge
    rst_n = 1'b0;
    start = 1'b0;
    in_operation = OP_PUSH;
    in_metric_0 = '0;
    in_metric_1 = '0;
    in_metric_2 = '0;
    in_metric_3 = '0;
    in_audio_present = 1'b0;
    in_audio_queue_in = '0;
    in_audio_underrun_in = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    wr_slot = 0;
    fill = 0;
    lat_ap = 1'b0;
    lat_aq = '0;
    lat_au = '0;
    interval_sel = '0;
    mismatches = 0;
    pushes_stored = 0;
    pushes_refused = 0;
    summaries = 0;
    beats_checked = 0;
    burst_left = 1;
    phase_cfg = '{32'd3, 32'd0, 32'd1, 32'hFFFF_FFFE};

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table. Typed rows carry their expectation; the rest go through the predictor.
    // empty window: all statistics zero
    dir_rows.push_back(row(OP_SUMMARY, 0, 0, 0, 0, 0, 0, 0, 1'b1));
    // all-zero sample, zero mean interval gives zero rate
    dir_rows.push_back(row(OP_PUSH, 0, 0, 0, 0, 0, 0, 0, 1'b1, 1'b1));
    dir_rows.push_back(row(OP_SUMMARY, 0, 0, 0, 0, 0, 0, 0));
    // largest metric values, audio at its extremes
    dir_rows.push_back(row(OP_PUSH, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                           32'h7FFF_FFFF, 1, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1));
    dir_rows.push_back(row(OP_SUMMARY, 0, 0, 0, 0, 0, 0, 0));
    // one negative metric in each position is refused
    dir_rows.push_back(row(OP_PUSH, 32'h8000_0000, 5, 5, 5, 0, 0, 0, 1'b1, 1'b0));
    dir_rows.push_back(row(OP_PUSH, 5, 32'hFFFF_FFFF, 5, 5, 0, 0, 0, 1'b1, 1'b0));
    dir_rows.push_back(row(OP_PUSH, 5, 5, 32'h8000_0001, 5, 0, 0, 0, 1'b1, 1'b0));
    dir_rows.push_back(row(OP_PUSH, 5, 5, 5, 32'hC000_0000, 0, 0, 0, 1'b1, 1'b0));
    // negative queue with audio present is refused
    dir_rows.push_back(row(OP_PUSH, 1, 2, 3, 4, 1, 32'h8000_0000, 7, 1'b1, 1'b0));
    // negative queue without audio is stored as zero
    dir_rows.push_back(row(OP_PUSH, 1, 2, 3, 4, 0, 32'hFFFF_FFFF, 9, 1'b1, 1'b1));
    dir_rows.push_back(row(OP_SUMMARY, 0, 0, 0, 0, 0, 0, 0));
    // samples of one LSB, audio present with zero and positive queue depth
    dir_rows.push_back(row(OP_PUSH, 1, 1, 1, 1, 1, 0, 0, 1'b1, 1'b1));
    dir_rows.push_back(row(OP_PUSH, 1, 1, 1, 1, 1, 32'h0000_4000, 3, 1'b1, 1'b1));
    dir_rows.push_back(row(OP_SUMMARY, 0, 0, 0, 0, 0, 0, 0));
    // typical 16 ms frames
    dir_rows.push_back(row(OP_PUSH, 32'h4000, 32'h4100, 32'h3F00, 32'h0800, 1, 32'h1000, 2));
    dir_rows.push_back(row(OP_PUSH, 32'h4200, 32'h3E00, 32'h4000, 32'h0900, 0, 32'h1000, 2));
    dir_rows.push_back(row(OP_SUMMARY, 0, 0, 0, 0, 0, 0, 0));
    foreach (dir_rows[i]) send_beat(dir_rows[i]);

    // Random phases, each under its own interval selection.
    for (int p = 0; p < 4; p++) begin
      drain_results();
      write_interval(phase_cfg[p]);
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
        // hold off once until the whole backlog has come out
        if (p == 1 && i == RANDOM_ITEMS / 2) drain_results();
        send_beat(pick_stim());
      end
    end

    drain_results();
    repeat (20) @(posedge clk);

    $display("covered %0d stored and %0d refused pushes, %0d summaries, %0d beats checked",
             pushes_stored, pushes_refused, summaries, beats_checked);
    $display("window wrapped %0d times across four interval selections",
             pushes_stored / WINDOW);
    if (mismatches == 0 && pending_stats.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
